FILE: rtl/owk_pkg.sv
package owk_pkg;

	localparam int WHEELS     = 3;
	localparam int COEF_W     = 21;
	localparam int VEL_W      = 16;
	localparam int SPD_W      = 32;
	localparam int STEP_W     = 16;
	localparam int ROW_W      = 3 * COEF_W;
	localparam int CFG_IDX_W  = 3;
	localparam int PROD_W     = COEF_W + VEL_W;
	localparam int ACC_W      = PROD_W + 2;
	localparam int MAG_W      = SPD_W + 1;
	localparam int NUM_W      = STEP_W + MAG_W;
	localparam int WIDX_W     = $clog2(WHEELS);
	localparam int KIDX_W     = 2;
	localparam int DCNT_W     = $clog2(STEP_W);

	localparam logic [STEP_W-1:0] MAX_STEP_RST = STEP_W'(512);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_FRONT      = 3'd0,
		REG_ROW_BACK_LEFT  = 3'd1,
		REG_ROW_BACK_RIGHT = 3'd2,
		REG_MAX_STEP       = 3'd3,
		REG_LIMIT_ENABLE   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic signed [VEL_W-1:0] vel_rot;
	} in_item_t;

	typedef struct packed {
		logic signed [SPD_W-1:0] front_speed;
		logic signed [SPD_W-1:0] back_left_speed;
		logic signed [SPD_W-1:0] back_right_speed;
		logic                    was_limited;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic              mul;
		logic              acc;
		logic              sat;
		logic              delta;
		logic              decide;
		logic              prod;
		logic              div_step;
		logic              upd;
		logic              out_load;
		logic [WIDX_W-1:0] wheel;
		logic [KIDX_W-1:0] k;
	} dp_cmd_t;

	typedef struct packed {
		logic div_needed;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: rtl/omni_wheel_kinematics_slew_limit.sv
// An item is taken only while idle; the next waits until the result is registered.
// When the slew limit scales the step, the 16-step shift-subtract divider is run
// once per wheel before the result register is loaded.
// Configuration writes are taken every cycle; the result register frees the input side.
// Reset clears coefficients and wheel speeds, sets max_step to 512 and limiting on.
module omni_wheel_kinematics_slew_limit
	import owk_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ROW_W-1:0]     cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	owk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	owk_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: rtl/owk_ctrl.sv
module owk_ctrl
	import owk_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_MUL    = 10'b0000000010,
		ST_ACC    = 10'b0000000100,
		ST_SAT    = 10'b0000001000,
		ST_DELTA  = 10'b0000010000,
		ST_DECIDE = 10'b0000100000,
		ST_PROD   = 10'b0001000000,
		ST_DIV    = 10'b0010000000,
		ST_UPD    = 10'b0100000000,
		ST_OUT    = 10'b1000000000
	} state_t;

	localparam logic [WIDX_W-1:0] W_LAST = WIDX_W'(WHEELS - 1);
	localparam logic [KIDX_W-1:0] K_LAST = KIDX_W'(2);
	localparam logic [DCNT_W-1:0] C_LAST = DCNT_W'(STEP_W - 1);

	state_t            state_q, state_n;
	logic [WIDX_W-1:0] w_q, w_n;
	logic [KIDX_W-1:0] k_q, k_n;
	logic [DCNT_W-1:0] cnt_q, cnt_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			w_q     <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			w_q     <= w_n;
			k_q     <= k_n;
			cnt_q   <= cnt_n;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_n      = state_q;
		w_n          = w_q;
		k_n          = k_q;
		cnt_n        = cnt_q;
		cmd          = '0;
		cmd.wheel    = w_q;
		cmd.k        = k_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					w_n       = '0;
					k_n       = '0;
					state_n   = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_n = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				if (k_q == K_LAST) begin
					state_n = ST_SAT;
				end else begin
					k_n     = k_q + KIDX_W'(1);
					state_n = ST_MUL;
				end
			end
			ST_SAT: begin
				cmd.sat = 1'b1;
				state_n = ST_DELTA;
			end
			ST_DELTA: begin
				cmd.delta = 1'b1;
				if (w_q == W_LAST) begin
					state_n = ST_DECIDE;
				end else begin
					w_n     = w_q + WIDX_W'(1);
					k_n     = '0;
					state_n = ST_MUL;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				if (sts.div_needed) begin
					w_n     = '0;
					state_n = ST_PROD;
				end else begin
					state_n = ST_OUT;
				end
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				cnt_n    = '0;
				state_n  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == C_LAST) begin
					state_n = ST_UPD;
				end else begin
					cnt_n = cnt_q + DCNT_W'(1);
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				if (w_q == W_LAST) begin
					state_n = ST_OUT;
				end else begin
					w_n     = w_q + WIDX_W'(1);
					state_n = ST_PROD;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/owk_dp.sv
module owk_dp
	import owk_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ROW_W-1:0]     cfg_data,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts
);

	logic [ROW_W-1:0]         rows_q [WHEELS];
	logic [STEP_W-1:0]        max_step_q;
	logic                     limit_en_q;

	in_item_t                 vel_q;
	logic signed [COEF_W-1:0] coef_sel;
	logic signed [VEL_W-1:0]  vel_sel;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [SPD_W-1:0]  sat_c;

	logic signed [SPD_W-1:0]  target_q [WHEELS];
	logic signed [SPD_W-1:0]  last_q [WHEELS];
	logic [MAG_W-1:0]         mag_q [WHEELS];
	logic                     neg_q [WHEELS];
	logic [MAG_W-1:0]         dmax_q;
	logic signed [MAG_W-1:0]  diff_c;
	logic [MAG_W-1:0]         mag_c;
	logic                     limited_c;
	logic                     limited_q;

	logic [NUM_W-1:0]         rem_q;
	logic [NUM_W-1:0]         dsh_q;
	logic [STEP_W-1:0]        quo_q;

	logic                     out_valid_q;
	out_item_t                out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WHEELS; i++) begin
				rows_q[i] <= '0;
			end
			max_step_q <= MAX_STEP_RST;
			limit_en_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROW_FRONT:      rows_q[0]  <= cfg_data;
				REG_ROW_BACK_LEFT:  rows_q[1]  <= cfg_data;
				REG_ROW_BACK_RIGHT: rows_q[2]  <= cfg_data;
				REG_MAX_STEP:       max_step_q <= cfg_data[STEP_W-1:0];
				REG_LIMIT_ENABLE:   limit_en_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (cmd.k)
			KIDX_W'(0): begin
				coef_sel = rows_q[cmd.wheel][COEF_W-1:0];
				vel_sel  = vel_q.vel_x;
			end
			KIDX_W'(1): begin
				coef_sel = rows_q[cmd.wheel][2*COEF_W-1:COEF_W];
				vel_sel  = vel_q.vel_y;
			end
			default: begin
				coef_sel = rows_q[cmd.wheel][3*COEF_W-1:2*COEF_W];
				vel_sel  = vel_q.vel_rot;
			end
		endcase
	end

	assign prod_c = PROD_W'(coef_sel) * PROD_W'(vel_sel);

	always_comb begin
		priority if (!acc_q[ACC_W-1] && (acc_q[ACC_W-2:SPD_W-1] != '0)) begin
			sat_c = {1'b0, {(SPD_W-1){1'b1}}};
		end else if (acc_q[ACC_W-1] && (acc_q[ACC_W-2:SPD_W-1] != '1)) begin
			sat_c = {1'b1, {(SPD_W-1){1'b0}}};
		end else begin
			sat_c = acc_q[SPD_W-1:0];
		end
	end

	assign diff_c    = MAG_W'(target_q[cmd.wheel]) - MAG_W'(last_q[cmd.wheel]);
	assign mag_c     = diff_c[MAG_W-1] ? MAG_W'(-diff_c) : MAG_W'(diff_c);
	assign limited_c = limit_en_q && (dmax_q >= MAG_W'(max_step_q));

	assign sts = '{div_needed: limited_c && (dmax_q != '0),
		out_free: !out_valid_q || out_ready};

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			vel_q <= in_data;
		end
		if (cmd.mul) begin
			prod_s1 <= prod_c;
		end
		if (cmd.start || cmd.sat) begin
			acc_q <= '0;
		end else if (cmd.acc) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
		if (cmd.sat) begin
			target_q[cmd.wheel] <= sat_c;
		end
		if (cmd.delta) begin
			mag_q[cmd.wheel] <= mag_c;
			neg_q[cmd.wheel] <= diff_c[MAG_W-1];
		end
		if (cmd.start) begin
			dmax_q <= '0;
		end else if (cmd.delta && (mag_c > dmax_q)) begin
			dmax_q <= mag_c;
		end
		if (cmd.decide) begin
			limited_q <= limited_c;
		end
		if (cmd.prod) begin
			rem_q <= NUM_W'(max_step_q) * NUM_W'(mag_q[cmd.wheel]);
			dsh_q <= NUM_W'(dmax_q) << (STEP_W - 1);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[STEP_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[STEP_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.out_load) begin
			out_q.front_speed      <= last_q[0];
			out_q.back_left_speed  <= last_q[1];
			out_q.back_right_speed <= last_q[2];
			out_q.was_limited      <= limited_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WHEELS; i++) begin
				last_q[i] <= '0;
			end
		end else if (cmd.decide && !limited_c) begin
			for (int i = 0; i < WHEELS; i++) begin
				last_q[i] <= target_q[i];
			end
		end else if (cmd.upd) begin
			if (neg_q[cmd.wheel]) begin
				last_q[cmd.wheel] <= last_q[cmd.wheel] - SPD_W'(quo_q);
			end else begin
				last_q[cmd.wheel] <= last_q[cmd.wheel] + SPD_W'(quo_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
